/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* design/ldws_pkg.sv */
// ----------------------------------------------------------------------------
// ldws_pkg
// Types, command codes and the digit table of the LED display sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldws_pkg;

  localparam int unsigned DigitsDef  = 6;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned InTdataW  = 24;
  localparam int unsigned InTuserW  = 3;
  localparam int unsigned OutTdataW = 8;

  localparam logic [7:0]  CmdDigitMode = 8'h44;
  localparam logic [7:0]  CmdBufMode   = 8'h40;
  localparam logic [7:0]  CmdAddrBase  = 8'hC0;
  localparam logic [7:0]  CmdDispOff   = 8'h80;
  localparam logic [7:0]  CmdDispOn    = 8'h88;
  localparam logic [15:0] AckTimeoutRst = 16'd255;

  // Action codes as they arrive on the stream.
  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_DIGIT  = 3'd1,
    ACT_LOAD   = 3'd2,
    ACT_SEND   = 3'd3,
    ACT_BRIGHT = 3'd4
  } act_e;

  // Kind of the transfer in flight.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DIGIT  = 2'd1,
    KIND_BUFFER = 2'd2,
    KIND_BRIGHT = 2'd3
  } kind_e;

  // Sequencer step within one frame.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_BITS  = 3'd2,
    ST_ACK   = 3'd3,
    ST_STOP  = 3'd4
  } seq_e;

  // Classified item handed from the front end to the sequencer.
  typedef struct packed {
    act_e       act;       // unused action codes already folded into a tick
    logic [2:0] addr;
    logic [7:0] byte_val;  // segment byte, or brightness command
    logic [2:0] len;       // saturated to the digit count
    logic       in_range;  // buffer slot exists
    logic       dio_in;
  } item_t;

  // Digit code to segment pattern: 0..9, blank, minus; blank above eleven.
  function automatic logic [7:0] seg_lut(input logic [7:0] code);
    logic [7:0] seg;
    case (code)
      8'd0:    seg = 8'h3f;
      8'd1:    seg = 8'h06;
      8'd2:    seg = 8'h5b;
      8'd3:    seg = 8'h4f;
      8'd4:    seg = 8'h66;
      8'd5:    seg = 8'h6d;
      8'd6:    seg = 8'h7d;
      8'd7:    seg = 8'h07;
      8'd8:    seg = 8'h7f;
      8'd9:    seg = 8'h6f;
      8'd10:   seg = 8'h00;
      8'd11:   seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* design/ldws_front.sv */
// ----------------------------------------------------------------------------
// ldws_front
// Input side: unpacks a stream item, decodes the action and prepares bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldws_front import ldws_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDef
) (
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InTuserW-1:0] s_axis_tuser_i,
  input  logic [InTdataW-1:0] s_axis_tdata_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output item_t               q_item_o
);

  logic [2:0] addr;
  logic [7:0] data;
  logic       encode;
  logic [2:0] len;
  logic       disp_on;
  logic [2:0] bright;
  logic [7:0] seg;

  assign addr    = s_axis_tdata_i[2:0];
  assign data    = s_axis_tdata_i[10:3];
  assign encode  = s_axis_tdata_i[11];
  assign len     = s_axis_tdata_i[14:12];
  assign disp_on = s_axis_tdata_i[15];
  assign bright  = s_axis_tdata_i[18:16];

  assign seg = encode ? seg_lut(data) : data;

  always_comb begin
    q_item_o          = '0;
    q_item_o.addr     = addr;
    q_item_o.dio_in   = s_axis_tdata_i[19];
    q_item_o.in_range = (32'(addr) < DIGITS);
    q_item_o.len      = (32'(len) > DIGITS) ? 3'(DIGITS) : len;
    q_item_o.byte_val = seg;
    case (s_axis_tuser_i)
      ACT_DIGIT:  q_item_o.act = ACT_DIGIT;
      ACT_LOAD:   q_item_o.act = ACT_LOAD;
      ACT_SEND:   q_item_o.act = ACT_SEND;
      ACT_BRIGHT: begin
        q_item_o.act      = ACT_BRIGHT;
        q_item_o.byte_val = disp_on ? (CmdDispOn | {5'd0, bright}) : CmdDispOff;
      end
      default:    q_item_o.act = ACT_TICK;
    endcase
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

endmodule

/* design/ldws_queue.sv */
// ----------------------------------------------------------------------------
// ldws_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldws_queue import ldws_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/ldws_seq.sv */
// ----------------------------------------------------------------------------
// ldws_seq
// Pin sequencer: one tick per item, display buffer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldws_seq import ldws_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [15:0]          cfg_wr_data_i,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned BufAw = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  seq_e        state_q, state_d;
  kind_e       kind_q, kind_d;
  logic        second_q, second_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  byte_idx_q, byte_idx_d;
  logic [15:0] wait_cnt_q, wait_cnt_d;
  logic [2:0]  paddr_q, paddr_d;
  logic [7:0]  pdata_q, pdata_d;
  logic [2:0]  plen_q, plen_d;
  logic        clk_lvl_q, clk_lvl_d;
  logic        dio_lvl_q, dio_lvl_d;
  logic [15:0] ack_timeout_q;

  logic [7:0]  disp_buf_q [DIGITS];
  logic        buf_we;
  logic [3:0]  buf_wr_addr;
  logic [7:0]  buf_rd;

  logic        out_valid_q;
  logic [4:0]  out_data_q;
  logic        pop;
  logic        ack_err, rej, ack_done;
  logic [7:0]  first_byte, head_byte, next_byte;
  logic [3:0]  frame_cnt, next_idx;

  assign pop     = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign q_pop_o = pop;

  assign buf_wr_addr = {1'b0, q_item_i.addr};
  assign buf_rd = (32'(byte_idx_q) < DIGITS) ? disp_buf_q[byte_idx_q[BufAw-1:0]] : 8'h00;

  // Bytes of the current frame.
  always_comb begin
    case (kind_q)
      KIND_DIGIT:  first_byte = CmdDigitMode;
      KIND_BUFFER: first_byte = CmdBufMode;
      default:     first_byte = pdata_q;
    endcase
    if (!second_q) begin
      head_byte = first_byte;
      next_byte = first_byte;
      frame_cnt = 4'd1;
    end else if (kind_q == KIND_DIGIT) begin
      head_byte = CmdAddrBase | {5'd0, paddr_q};
      next_byte = pdata_q;
      frame_cnt = 4'd2;
    end else begin
      head_byte = CmdAddrBase;
      next_byte = buf_rd;
      frame_cnt = 4'd1 + {1'b0, plen_q};
    end
  end

  assign next_idx = byte_idx_q + 4'd1;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    second_d   = second_q;
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    byte_idx_d = byte_idx_q;
    wait_cnt_d = wait_cnt_q;
    paddr_d    = paddr_q;
    pdata_d    = pdata_q;
    plen_d     = plen_q;
    clk_lvl_d  = clk_lvl_q;
    dio_lvl_d  = dio_lvl_q;
    buf_we     = 1'b0;
    ack_err    = 1'b0;
    rej        = 1'b0;
    ack_done   = 1'b0;

    if (state_q == ST_IDLE) begin
      case (q_item_i.act)
        ACT_DIGIT: begin
          kind_d  = KIND_DIGIT;
          paddr_d = q_item_i.addr;
          pdata_d = q_item_i.byte_val;
        end
        ACT_LOAD: buf_we = q_item_i.in_range;
        ACT_SEND: begin
          kind_d = KIND_BUFFER;
          plen_d = q_item_i.len;
        end
        ACT_BRIGHT: begin
          kind_d  = KIND_BRIGHT;
          pdata_d = q_item_i.byte_val;
        end
        default: ;
      endcase
      if (q_item_i.act == ACT_DIGIT || q_item_i.act == ACT_SEND ||
          q_item_i.act == ACT_BRIGHT) begin
        state_d    = ST_START;
        second_d   = 1'b0;
        phase_d    = 2'd0;
        byte_idx_d = 4'd0;
        bit_cnt_d  = 4'd0;
      end
    end else begin
      rej = (q_item_i.act != ACT_TICK);
      case (state_q)
        ST_START: begin
          if (phase_q == 2'd0) begin
            clk_lvl_d = 1'b1;
            dio_lvl_d = 1'b1;
            phase_d   = 2'd1;
          end else begin
            dio_lvl_d  = 1'b0;
            byte_idx_d = 4'd0;
            bit_cnt_d  = 4'd0;
            shift_d    = head_byte;
            phase_d    = 2'd0;
            state_d    = ST_BITS;
          end
        end
        ST_BITS: begin
          if (phase_q == 2'd0) begin
            clk_lvl_d = 1'b0;
            phase_d   = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl_d = shift_q[0];
            phase_d   = 2'd2;
          end else begin
            clk_lvl_d = 1'b1;
            shift_d   = {1'b0, shift_q[7:1]};
            bit_cnt_d = bit_cnt_q + 4'd1;
            phase_d   = 2'd0;
            if (bit_cnt_q >= 4'd7) begin
              wait_cnt_d = 16'd0;
              state_d    = ST_ACK;
            end
          end
        end
        ST_ACK: begin
          if (phase_q == 2'd0) begin
            clk_lvl_d = 1'b0;
            phase_d   = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl_d = 1'b1;
            phase_d   = 2'd2;
          end else begin
            // Ack is taken from the sampled pin, not from the driven level.
            if (!q_item_i.dio_in) begin
              ack_done = 1'b1;
            end else if (wait_cnt_q >= ack_timeout_q) begin
              ack_err  = 1'b1;
              ack_done = 1'b1;
            end else begin
              wait_cnt_d = wait_cnt_q + 16'd1;
            end
            if (ack_done) begin
              clk_lvl_d  = 1'b1;
              byte_idx_d = next_idx;
              phase_d    = 2'd0;
              if (next_idx < frame_cnt) begin
                shift_d   = next_byte;
                bit_cnt_d = 4'd0;
                state_d   = ST_BITS;
              end else begin
                state_d = ST_STOP;
              end
            end
          end
        end
        ST_STOP: begin
          if (phase_q == 2'd0) begin
            clk_lvl_d = 1'b0;
            phase_d   = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl_d = 1'b0;
            phase_d   = 2'd2;
          end else if (phase_q == 2'd2) begin
            clk_lvl_d = 1'b1;
            phase_d   = 2'd3;
          end else begin
            dio_lvl_d = 1'b1;
            phase_d   = 2'd0;
            if (!second_q && kind_q != KIND_BRIGHT) begin
              state_d  = ST_START;
              second_d = 1'b1;
            end else begin
              state_d  = ST_IDLE;
              second_d = 1'b0;
            end
          end
        end
        default: begin
          state_d  = ST_IDLE;
          second_d = 1'b0;
          phase_d  = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= KIND_NONE;
      second_q   <= 1'b0;
      phase_q    <= 2'd0;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'd0;
      byte_idx_q <= 4'd0;
      wait_cnt_q <= 16'd0;
      paddr_q    <= 3'd0;
      pdata_q    <= 8'd0;
      plen_q     <= 3'd0;
      clk_lvl_q  <= 1'b1;
      dio_lvl_q  <= 1'b1;
    end else if (pop) begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      second_q   <= second_d;
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      byte_idx_q <= byte_idx_d;
      wait_cnt_q <= wait_cnt_d;
      paddr_q    <= paddr_d;
      pdata_q    <= pdata_d;
      plen_q     <= plen_d;
      clk_lvl_q  <= clk_lvl_d;
      dio_lvl_q  <= dio_lvl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_wr_en_i) begin
      ack_timeout_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && buf_we) begin
      disp_buf_q[buf_wr_addr[BufAw-1:0]] <= q_item_i.byte_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= {rej, ack_err, (state_d != ST_IDLE), dio_lvl_d, clk_lvl_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_data_q};

endmodule

/* design/led_display_two_wire_sender_unit.sv */
// ----------------------------------------------------------------------------
// led_display_two_wire_sender_unit
// Tick-driven serializer for a two-wire LED display driver.
// ----------------------------------------------------------------------------
//  Channel        Direction  Item contents
//  s_axis         in         one pin tick, optionally carrying a command
//  m_axis         out        pin levels and status after that tick
//  cfg_wr         in         ack timeout in ticks, 16 bits
//
// Every input item yields exactly one output item. The block takes one item
// per clock cycle while the output is not stalled. An item is held in the
// queue and then in the result register, from which its result leaves. The
// sequencer applies one tick per cycle while the output is not stalled, and
// its state registers advance only when an item is popped. Reset clears all
// control state and restores an ack timeout of 255; the display buffer is
// not cleared and holds garbage until loaded. A stall on the output side fills
// the two-entry queue, after which the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_display_two_wire_sender_unit import ldws_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: ack timeout, written whenever the enable is high.
  input  logic                 cfg_wr_en_i,
  input  logic [15:0]          cfg_wr_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tuser, low bit up: action[2:0]
  input  logic [InTuserW-1:0]  s_axis_tuser_i,
  // tdata, low bit up: address[2:0], data[10:3], encode[11], length[14:12],
  // display_on[15], brightness[18:16], dio_in[19], zeros[23:20]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // Output stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata, low bit up: clk_res[0], dio[1], busy_res[2], ack_error[3],
  // cmd_rejected[4], zeros[7:5]
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  logic  q_push, q_full, q_valid, q_pop;
  item_t push_item, head_item;

  // Front end: unpack and classify each item.
  ldws_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  // Queue decoupling input handshake from the sequencer.
  ldws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (head_item)
  );

  // Back end: bus sequencer, display buffer and result register.
  ldws_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`include "assert_macros.svh"

  // A tick taken from the queue always shows up as a result next cycle.
  `ASSERT_AT(a_pop_gives_result, q_pop |=> m_axis_tvalid_o, "popped tick produced no result")
  // An ack timeout leaves a transfer running and raises the clock line.
  `ASSERT_NEVER(a_ackerr_busy, m_axis_tvalid_o && m_axis_tdata_o[3] && !m_axis_tdata_o[2], "ack error while idle")
  `ASSERT_NEVER(a_ackerr_clk, m_axis_tvalid_o && m_axis_tdata_o[3] && !m_axis_tdata_o[0], "ack error with clock low")

endmodule

/* bench/tb_led_display_two_wire_sender_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_display_two_wire_sender_unit
// Self-checking bench for the two-wire LED display sender: every tick item is
// mirrored in a bench-side sequencer and the pin levels and flags that come
// back are compared against it under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb_led_display_two_wire_sender_unit;
  import ldws_pkg::*;

  localparam int unsigned DIGITS       = DigitsDef;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          SETTLE_TICKS = 6;    // result path is the queue and the result register
  localparam int          TOTAL_ITEMS  = 1200;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          MAX_REPORTS  = 50;

  // Segment patterns for digit codes 0..9, blank and minus; entry 0 sits lowest.
  localparam logic [12*8-1:0] GLYPHS = {8'h40, 8'h00, 8'h6f, 8'h7f, 8'h07, 8'h7d,
                                        8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};
  localparam logic [7:0]      BLANK_SEGMENTS = 8'h00;

  // One input item, field for field as it travels in tuser and tdata.
  typedef struct {
    logic [2:0] act;
    logic [2:0] addr;
    logic [7:0] data;
    logic       enc;
    logic [2:0] len;
    logic       on;
    logic [2:0] bri;
    logic       din;
  } sender_item_t;

  // One result item: pin levels and status flags after a tick.
  typedef struct packed {
    logic rejected;
    logic ack_err;
    logic busy;
    logic dio;
    logic clk;
  } pin_state_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [15:0]          cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTuserW-1:0]  s_axis_tuser = '0;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  led_display_two_wire_sender_unit #(
    .DIGITS(DIGITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench copy of the sequencer. The frame flag is kept apart from the step so
  // that the package's step encoding can be used as it is.
  // --------------------------------------------------------------------------
  logic [15:0] ack_limit = AckTimeoutRst;
  seq_e        step_q    = ST_IDLE;
  logic        second_q  = 1'b0;    // set while the address/data frame runs
  logic [1:0]  phase_q   = '0;
  logic [3:0]  bits_q    = '0;
  logic [7:0]  shreg     = '0;
  logic [2:0]  idx_q     = '0;
  logic [15:0] wait_q    = '0;
  kind_e       kind_q    = KIND_NONE;
  logic [2:0]  addr_q    = '0;
  logic [7:0]  byte_q    = '0;
  logic [2:0]  len_q     = '0;
  logic        clk_lvl   = 1'b1;
  logic        dio_lvl   = 1'b1;
  logic [7:0]  seg_buf [DIGITS];

  pin_state_t  pins_due [$];        // expected results, oldest first
  int          fault_count = 0;
  int          sent_items  = 0;     // items accepted by the block
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          sink_tick   = 0;
  int          sink_mode   = 0;
  pin_state_t  want_pins;
  pin_state_t  got_pins;

  function automatic logic [7:0] segments_for(logic [7:0] code, logic enc);
    if (!enc) return code;
    if (code < 8'd12) return GLYPHS[8*int'(code) +: 8];
    return BLANK_SEGMENTS;
  endfunction

  // Byte number idx of the current frame. The first frame carries only the
  // mode byte, or the brightness command itself.
  function automatic logic [7:0] frame_octet(logic second, int idx);
    if (!second) begin
      if (kind_q == KIND_DIGIT) return CmdDigitMode;
      if (kind_q == KIND_BUFFER) return CmdBufMode;
      return byte_q;
    end
    if (idx == 0) return (kind_q == KIND_DIGIT) ? (CmdAddrBase | {5'b0, addr_q}) : CmdAddrBase;
    if (kind_q == KIND_DIGIT) return byte_q;
    return seg_buf[idx-1];
  endfunction

  // Applies one accepted item to the bench sequencer and returns the result
  // the block must produce for it.
  function automatic pin_state_t predict_pins(sender_item_t it);
    pin_state_t r;
    logic       starts;
    logic       done;
    int         frame_total;
    r      = '0;
    starts = 1'b0;
    if (step_q == ST_IDLE) begin
      case (it.act)
        ACT_DIGIT: begin
          kind_q = KIND_DIGIT;
          addr_q = it.addr;
          byte_q = segments_for(it.data, it.enc);
          starts = 1'b1;
        end
        ACT_LOAD: begin
          if (it.addr < DIGITS) seg_buf[it.addr] = segments_for(it.data, it.enc);
        end
        ACT_SEND: begin
          kind_q = KIND_BUFFER;
          len_q  = (it.len > DIGITS) ? 3'(DIGITS) : it.len;
          starts = 1'b1;
        end
        ACT_BRIGHT: begin
          kind_q = KIND_BRIGHT;
          byte_q = it.on ? (CmdDispOn | {5'b0, it.bri}) : CmdDispOff;
          starts = 1'b1;
        end
        default: ;
      endcase
      // The accepting tick leaves the pins where they are.
      if (starts) begin
        step_q   = ST_START;
        second_q = 1'b0;
        phase_q  = '0;
        idx_q    = '0;
        bits_q   = '0;
      end
    end else begin
      // Commands while busy are dropped, but the item still advances the pins.
      r.rejected = (it.act >= ACT_DIGIT) && (it.act <= ACT_BRIGHT);
      case (step_q)
        ST_START: begin
          if (phase_q == 2'd0) begin
            clk_lvl = 1'b1;
            dio_lvl = 1'b1;
            phase_q = 2'd1;
          end else begin
            dio_lvl = 1'b0;
            idx_q   = '0;
            bits_q  = '0;
            shreg   = frame_octet(second_q, 0);
            phase_q = 2'd0;
            step_q  = ST_BITS;
          end
        end
        ST_BITS: begin
          if (phase_q == 2'd0) begin
            clk_lvl = 1'b0;
            phase_q = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl = shreg[0];
            phase_q = 2'd2;
          end else begin
            clk_lvl = 1'b1;
            shreg   = shreg >> 1;
            bits_q  = bits_q + 4'd1;
            phase_q = 2'd0;
            if (bits_q >= 4'd8) begin
              wait_q = '0;
              step_q = ST_ACK;
            end
          end
        end
        ST_ACK: begin
          if (phase_q == 2'd0) begin
            clk_lvl = 1'b0;
            phase_q = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl = 1'b1;
            phase_q = 2'd2;
          end else begin
            // The ack is taken from the pin sample; a timeout flags and moves on.
            done = 1'b0;
            if (!it.din) begin
              done = 1'b1;
            end else if (wait_q >= ack_limit) begin
              r.ack_err = 1'b1;
              done      = 1'b1;
            end else begin
              wait_q = wait_q + 16'd1;
            end
            if (done) begin
              clk_lvl     = 1'b1;
              idx_q       = idx_q + 3'd1;
              phase_q     = 2'd0;
              frame_total = !second_q ? 1 : (kind_q == KIND_DIGIT) ? 2 : 1 + int'(len_q);
              if (int'(idx_q) < frame_total) begin
                shreg  = frame_octet(second_q, int'(idx_q));
                bits_q = '0;
                step_q = ST_BITS;
              end else begin
                step_q = ST_STOP;
              end
            end
          end
        end
        ST_STOP: begin
          if (phase_q == 2'd0) begin
            clk_lvl = 1'b0;
            phase_q = 2'd1;
          end else if (phase_q == 2'd1) begin
            dio_lvl = 1'b0;
            phase_q = 2'd2;
          end else if (phase_q == 2'd2) begin
            clk_lvl = 1'b1;
            phase_q = 2'd3;
          end else begin
            dio_lvl = 1'b1;
            phase_q = 2'd0;
            // Brightness is a single frame; the others go on to the second one.
            if (!second_q && kind_q != KIND_BRIGHT) begin
              second_q = 1'b1;
              step_q   = ST_START;
            end else begin
              second_q = 1'b0;
              step_q   = ST_IDLE;
            end
          end
        end
        default: begin
          step_q  = ST_IDLE;
          phase_q = '0;
        end
      endcase
    end
    r.clk  = clk_lvl;
    r.dio  = dio_lvl;
    r.busy = (step_q != ST_IDLE);
    return r;
  endfunction

  function automatic sender_item_t rand_item();
    sender_item_t it;
    it.act  = 3'($urandom_range(7));
    it.addr = 3'($urandom_range(7));
    it.data = 8'($urandom_range(255));
    it.enc  = 1'($urandom_range(1));
    it.len  = 3'($urandom_range(7));
    it.on   = 1'($urandom_range(1));
    it.bri  = 3'($urandom_range(7));
    it.din  = 1'($urandom_range(1));
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Source side. Items go out in bursts of random length with random gaps in
  // front; a burst with a zero gap keeps valid high across items.
  // --------------------------------------------------------------------------
  task automatic send_item(input sender_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3) != 0) gap = $urandom_range(5, 1);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.act;
    s_axis_tdata  <= {4'b0, it.din, it.bri, it.on, it.len, it.enc, it.data, it.addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    pins_due.push_back(predict_pins(it));
  endtask

  // Sends ticks until the transfer in flight has ended. low_pct sets how often
  // the display pulls the data pin low; noise_pct mixes in other actions,
  // which the block must reject or treat as ticks while it is busy.
  task automatic run_out(input int low_pct, input int noise_pct);
    sender_item_t it;
    while (step_q != ST_IDLE) begin
      it = rand_item();
      if ($urandom_range(99) >= noise_pct) it.act = ACT_TICK;
      it.din = ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
      send_item(it);
    end
  endtask

  task automatic issue_command(input logic [2:0] act, input logic [2:0] addr,
                               input logic [7:0] data, input logic enc,
                               input logic [2:0] len, input logic on,
                               input logic [2:0] bri, input int low_pct);
    sender_item_t it;
    it      = rand_item();
    it.act  = act;
    it.addr = addr;
    it.data = data;
    it.enc  = enc;
    it.len  = len;
    it.on   = on;
    it.bri  = bri;
    send_item(it);
    run_out(low_pct, 0);
  endtask

  // Holds the source off until every expected result has been seen and the
  // result path has had time to empty.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // The timeout register is only touched with the sequencer idle and the
  // pipeline empty.
  task automatic set_ack_limit(input logic [15:0] value);
    run_out(50, 0);
    settle();
    @(negedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk_i);
    cfg_wr_en   <= 1'b0;
    ack_limit = value;
  endtask

  // --------------------------------------------------------------------------
  // Sink side: a stall pattern that is drawn anew from time to time, from
  // always ready through random and periodic stalls to long holds.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sink_tick++;
    if (sink_tick % 200 == 0) sink_mode = $urandom_range(3);
    case (sink_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(1));
      2:       m_axis_tready <= (sink_tick % 5) < 3;
      default: m_axis_tready <= (sink_tick % 40) >= 9;
    endcase
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_pins = m_axis_tdata[4:0];
      if (pins_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %05b", $time, got_pins);
      end else begin
        want_pins = pins_due.pop_front();
        check_field("clk_res", want_pins.clk, got_pins.clk);
        check_field("dio", want_pins.dio, got_pins.dio);
        check_field("busy_res", want_pins.busy, got_pins.busy);
        check_field("ack_error", want_pins.ack_err, got_pins.ack_err);
        check_field("cmd_rejected", want_pins.rejected, got_pins.rejected);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_display_two_wire_sender_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // Fills every buffer slot first, so no send ever reads an unwritten entry,
  // then sends the buffer with an empty and an oversized length, the latter
  // clipped to the whole buffer.
  task automatic test_buffer_path();
    issue_command(ACT_LOAD, 3'd0, 8'h00, 1'b0, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_LOAD, 3'd1, 8'hff, 1'b0, 3'd7, 1'b1, 3'd7, 80);
    issue_command(ACT_LOAD, 3'd2, 8'd10, 1'b1, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_LOAD, 3'd3, 8'd11, 1'b1, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_LOAD, 3'd4, 8'd12, 1'b1, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_LOAD, 3'd5, 8'd9, 1'b1, 3'd0, 1'b0, 3'd0, 80);
    // Slots beyond the buffer are ignored.
    issue_command(ACT_LOAD, 3'd6, 8'h55, 1'b0, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_LOAD, 3'd7, 8'haa, 1'b0, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_SEND, 3'd0, 8'h00, 1'b0, 3'd0, 1'b0, 3'd0, 80);
    issue_command(ACT_SEND, 3'd7, 8'hff, 1'b1, 3'd7, 1'b1, 3'd7, 80);
  endtask

  // Digit writes at both address extremes, one raw and one encoded with a
  // code above the table that must go out blank.
  task automatic test_digit_writes();
    issue_command(ACT_DIGIT, 3'd7, 8'hff, 1'b0, 3'd7, 1'b1, 3'd7, 80);
    issue_command(ACT_DIGIT, 3'd0, 8'hff, 1'b1, 3'd0, 1'b0, 3'd0, 80);
  endtask

  task automatic test_brightness();
    issue_command(ACT_BRIGHT, 3'd0, 8'h00, 1'b0, 3'd0, 1'b0, 3'd7, 80);
    issue_command(ACT_BRIGHT, 3'd7, 8'hff, 1'b1, 3'd7, 1'b1, 3'd7, 80);
  endtask

  // Action codes 1 to 7 arrive right behind a command that started a transfer.
  task automatic test_busy_commands();
    sender_item_t it;
    it     = rand_item();
    it.act = ACT_DIGIT;
    send_item(it);
    for (int a = 1; a < 8; a++) begin
      it     = rand_item();
      it.act = 3'(a);
      send_item(it);
    end
    run_out(80, 20);
  endtask

  // Ack handling at the timeout extremes: no wait at all and a short wait,
  // both with the pin held high, then the largest value and the reset value
  // with acks that come late.
  task automatic test_ack_limits();
    set_ack_limit(16'd0);
    issue_command(ACT_BRIGHT, 3'd0, 8'h00, 1'b0, 3'd0, 1'b1, 3'd2, 0);
    set_ack_limit(16'd3);
    issue_command(ACT_BRIGHT, 3'd0, 8'h00, 1'b0, 3'd0, 1'b1, 3'd5, 0);
    set_ack_limit(16'hffff);
    issue_command(ACT_BRIGHT, 3'd0, 8'h00, 1'b0, 3'd0, 1'b0, 3'd0, 60);
    set_ack_limit(AckTimeoutRst);
    issue_command(ACT_DIGIT, 3'd1, 8'd3, 1'b1, 3'd0, 1'b0, 3'd0, 40);
  endtask

  // Random traffic in phases, each with its own ack timeout, until the item
  // total is reached. Most of it is a command followed by ticks until the
  // transfer ends, with some rejected commands mixed in; the rest is loose
  // items and runs of idle ticks.
  task automatic test_random_traffic();
    sender_item_t it;
    int           pick;
    int           low_pct;
    int           phase_start;
    logic [15:0]  limit;
    while (sent_items < TOTAL_ITEMS) begin
      pick = $urandom_range(4);
      case (pick)
        0:       limit = 16'd0;
        1:       limit = 16'hffff;
        2:       limit = 16'($urandom_range(65535));
        default: limit = 16'($urandom_range(12));
      endcase
      set_ack_limit(limit);
      // Long timeouts need the acks to come, or one phase would run forever.
      low_pct     = (limit > 16'd64) ? $urandom_range(90, 30) : $urandom_range(100);
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS && sent_items < TOTAL_ITEMS) begin
        pick = $urandom_range(99);
        it   = rand_item();
        if (pick < 70) begin
          it.act = 3'($urandom_range(4, 1));
          send_item(it);
          run_out(low_pct, 10);
        end else if (pick < 85) begin
          send_item(it);
        end else begin
          repeat ($urandom_range(12, 1)) begin
            it     = rand_item();
            it.act = ACT_TICK;
            send_item(it);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_buffer_path();
    test_digit_writes();
    test_brightness();
    test_busy_commands();
    test_ack_limits();
    test_random_traffic();
    run_out(50, 0);
    settle();
    if (fault_count == 0) begin
      $display("led_display_two_wire_sender_unit regression: pass");
    end else begin
      $display("led_display_two_wire_sender_unit regression: fail");
    end
    $finish;
  end

endmodule
